@@ sv/occultation_record_parser_core_assert.svh @@
// Assertion macros shared by the parser core modules.
`ifndef OCCULTATION_RECORD_PARSER_CORE_ASSERT_SVH
`define OCCULTATION_RECORD_PARSER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ORP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ORP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/orp_pkg.sv @@
`timescale 1ns / 1ps

package orp_pkg;

  // File header length in bytes.
  localparam logic [6:0] HEADER_BYTES = 7'd64;

  // Result kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_TAP    = 1'b1;

  // Register index on the configuration port.
  localparam logic REG_TAP_COUNT      = 1'b0;
  localparam logic REG_AMP_PHASE_MODE = 1'b1;

  typedef enum logic [1:0] {
    ST_TIME,
    ST_PHASE,
    ST_WORD1,
    ST_WORD2
  } orp_stage_t;

  // Parsed item handed from the parse stage to the tap math stage.
  typedef struct packed {
    logic        kind;
    logic [47:0] time_offset;
    logic [39:0] carrier_phase;
    logic [5:0]  tap_index;
    logic        last_tap;
    logic        amp_mode;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [17:0] cos_val;
    logic [17:0] sin_val;
  } orp_item_t;

  // round(65536 * sin(k * pi / 128)) for k = 0..64.
  localparam logic [16:0] QUARTER_SIN [0:64] = '{
    17'd0,     17'd1608,  17'd3216,  17'd4821,  17'd6424,  17'd8022,
    17'd9616,  17'd11204, 17'd12785, 17'd14359, 17'd15924, 17'd17479,
    17'd19024, 17'd20557, 17'd22078, 17'd23586, 17'd25080, 17'd26558,
    17'd28020, 17'd29466, 17'd30893, 17'd32303, 17'd33692, 17'd35062,
    17'd36410, 17'd37736, 17'd39040, 17'd40320, 17'd41576, 17'd42806,
    17'd44011, 17'd45190, 17'd46341, 17'd47464, 17'd48559, 17'd49624,
    17'd50660, 17'd51665, 17'd52639, 17'd53581, 17'd54491, 17'd55368,
    17'd56212, 17'd57022, 17'd57798, 17'd58538, 17'd59244, 17'd59914,
    17'd60547, 17'd61145, 17'd61705, 17'd62228, 17'd62714, 17'd63162,
    17'd63572, 17'd63944, 17'd64277, 17'd64571, 17'd64827, 17'd65043,
    17'd65220, 17'd65358, 17'd65457, 17'd65516, 17'd65536
  };

  // Q1.16 sine of angle 2*pi*p/256, folded from the quarter wave.
  function automatic logic signed [17:0] sin_q16(input logic [7:0] p);
    logic [6:0]  idx;
    logic [17:0] mag;
    idx = p[6] ? (7'd64 - {1'b0, p[5:0]}) : {1'b0, p[5:0]};
    mag = {1'b0, QUARTER_SIN[idx]};
    return p[7] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

@@ sv/occultation_record_parser_core.sv @@
`timescale 1ns / 1ps

// Radio-occultation record parser. One file byte is taken per transfer on the
// input channel, at up to one byte per clock cycle; the first 64 bytes (file
// header) are absorbed without results. Each record yields one header result
// (time offset and carrier phase) followed by tap_count tap results, the last
// flagged by last_tap. The byte that completes a result is assembled and looked
// up in the cosine/sine table in the parse stage, which registers the item; the
// tap math stage (amplitude multiply and truncation toward zero when
// amp_phase_mode is set) then loads it into the output register. The input
// stalls only while both stages hold results and the output is stalled. tap_count
// of zero behaves as one. Write tap_count (address 0) and amp_phase_mode
// (address 4) only while the block is idle.
module occultation_record_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                item_kind,
  output logic [47:0]         time_offset,
  output logic signed [39:0]  carrier_phase,
  output logic [5:0]          tap_index,
  output logic signed [16:0]  i_value,
  output logic signed [16:0]  q_value,
  output logic                last_tap
);

  logic               tap_count_wr;
  logic [5:0]         tap_count;
  logic               amp_phase_mode;
  logic               cfg_wr;
  logic               s1_valid;
  logic               s1_stall;
  orp_pkg::orp_item_t s1_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign tap_count_wr = cfg_wr && (paddr[2] == orp_pkg::REG_TAP_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count      <= 6'd1;
      amp_phase_mode <= 1'b0;
    end else if (cfg_wr) begin
      if (tap_count_wr) begin
        tap_count <= pwdata[5:0];
      end else begin
        amp_phase_mode <= pwdata[0];
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      orp_pkg::REG_TAP_COUNT:      prdata = {26'd0, tap_count};
      orp_pkg::REG_AMP_PHASE_MODE: prdata = {31'd0, amp_phase_mode};
      default:                     prdata = '0;
    endcase
  end

  orp_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .tap_count      (tap_count),
    .amp_phase_mode (amp_phase_mode),
    .s1_valid       (s1_valid),
    .s1_stall       (s1_stall),
    .s1_item        (s1_item)
  );

  orp_tap_math u_tap_math (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1_stall      (s1_stall),
    .s1_item       (s1_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .item_kind     (item_kind),
    .time_offset   (time_offset),
    .carrier_phase (carrier_phase),
    .tap_index     (tap_index),
    .i_value       (i_value),
    .q_value       (q_value),
    .last_tap      (last_tap)
  );

endmodule

@@ sv/orp_parser.sv @@
`timescale 1ns / 1ps

module orp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic [5:0]          tap_count,
  input  logic                amp_phase_mode,
  output logic                s1_valid,
  input  logic                s1_stall,
  output orp_pkg::orp_item_t  s1_item
);

  logic [6:0]           hdr_rem;
  orp_pkg::orp_stage_t  stage;
  orp_pkg::orp_stage_t  stage_next;
  logic [2:0]           bif;
  logic [2:0]           bif_next;
  logic [5:0]           tap_cnt;
  logic [5:0]           tap_cnt_next;
  logic [47:0]          asm_sh;
  logic [47:0]          asm_next;
  logic [47:0]          asm_new;
  logic [15:0]          fwh;
  logic [15:0]          fwh_next;
  logic [47:0]          time_hold;
  logic [47:0]          time_hold_next;
  logic                 accept;
  logic                 in_record;
  logic                 field_done;
  logic                 last;
  logic                 emit;
  logic [3:0]           tap_len;
  orp_pkg::orp_item_t   item_next;

  assign in_stall  = s1_valid && s1_stall;
  assign accept    = in_valid && !in_stall;
  assign in_record = (hdr_rem == 7'd0);
  assign tap_len   = amp_phase_mode ? 4'd1 : 4'd2;
  assign last      = ({1'b0, tap_cnt} + 7'd1) >= {1'b0, tap_count};

  // Merge the new byte into its little-endian lane.
  always_comb begin
    asm_new = asm_sh;
    for (int l = 0; l < 6; l++) begin
      if (bif == 3'(l)) begin
        asm_new[8*l +: 8] = asm_sh[8*l +: 8] | in_byte;
      end
    end
  end

  always_comb begin
    unique case (stage)
      orp_pkg::ST_TIME:  field_done = (bif >= 3'd5);
      orp_pkg::ST_PHASE: field_done = (bif >= 3'd4);
      orp_pkg::ST_WORD1: field_done = (bif >= 3'd1);
      orp_pkg::ST_WORD2: field_done = (({1'b0, bif} + 4'd1) >= tap_len);
      default:           field_done = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    stage_next = stage;
    if (accept && in_record && field_done) begin
      unique case (stage)
        orp_pkg::ST_TIME:  stage_next = orp_pkg::ST_PHASE;
        orp_pkg::ST_PHASE: stage_next = orp_pkg::ST_WORD1;
        orp_pkg::ST_WORD1: stage_next = orp_pkg::ST_WORD2;
        orp_pkg::ST_WORD2: stage_next = last ? orp_pkg::ST_TIME : orp_pkg::ST_WORD1;
        default:           stage_next = orp_pkg::ST_TIME;
      endcase
    end
  end

  // Field assembly and emitted item
  always_comb begin
    bif_next       = bif;
    tap_cnt_next   = tap_cnt;
    asm_next       = asm_sh;
    fwh_next       = fwh;
    time_hold_next = time_hold;
    emit           = 1'b0;
    item_next      = '0;
    if (in_record) begin
      if (field_done) begin
        asm_next = '0;
        bif_next = 3'd0;
      end else begin
        asm_next = asm_new;
        bif_next = bif + 3'd1;
      end
      unique case (stage)
        orp_pkg::ST_TIME: begin
          if (field_done) begin
            time_hold_next = asm_new;
          end
        end
        orp_pkg::ST_PHASE: begin
          if (field_done) begin
            emit                    = 1'b1;
            tap_cnt_next            = 6'd0;
            item_next.kind          = orp_pkg::KIND_HEADER;
            item_next.time_offset   = time_hold;
            item_next.carrier_phase = asm_new[39:0];
          end
        end
        orp_pkg::ST_WORD1: begin
          if (field_done) begin
            fwh_next = asm_new[15:0];
          end
        end
        orp_pkg::ST_WORD2: begin
          if (field_done) begin
            emit               = 1'b1;
            tap_cnt_next       = last ? 6'd0 : tap_cnt + 6'd1;
            item_next.kind     = orp_pkg::KIND_TAP;
            item_next.tap_index = tap_cnt;
            item_next.last_tap = last;
            item_next.amp_mode = amp_phase_mode;
            item_next.word_a   = fwh;
            item_next.word_b   = asm_new[15:0];
            item_next.cos_val  = orp_pkg::sin_q16(asm_new[7:0] + 8'd64);
            item_next.sin_val  = orp_pkg::sin_q16(asm_new[7:0]);
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_rem   <= orp_pkg::HEADER_BYTES;
      stage     <= orp_pkg::ST_TIME;
      bif       <= 3'd0;
      tap_cnt   <= 6'd0;
      asm_sh    <= '0;
      fwh       <= '0;
      time_hold <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (!in_record) begin
          hdr_rem <= hdr_rem - 7'd1;
        end else begin
          stage     <= stage_next;
          bif       <= bif_next;
          tap_cnt   <= tap_cnt_next;
          asm_sh    <= asm_next;
          fwh       <= fwh_next;
          time_hold <= time_hold_next;
        end
      end
      if (!in_stall) begin
        s1_valid <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item <= item_next;
    end
  end

  `include "occultation_record_parser_core_assert.svh"

  `ORP_ASSERT_NOW(a_header_skip_idle, clk, rst, hdr_rem != 7'd0,
    stage == orp_pkg::ST_TIME && bif == 3'd0 && tap_cnt == 6'd0,
    "record state moved inside file header")
  `ORP_ASSERT_NEXT(a_header_no_item, clk, rst, accept && hdr_rem != 7'd0, !s1_valid,
    "item produced from a file header byte")
  `ORP_ASSERT_NOW(a_emit_stage, clk, rst, accept && emit,
    stage == orp_pkg::ST_PHASE || stage == orp_pkg::ST_WORD2,
    "item emitted outside phase or tap field")

endmodule

@@ sv/orp_tap_math.sv @@
`timescale 1ns / 1ps

module orp_tap_math (
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_valid,
  output logic                s1_stall,
  input  orp_pkg::orp_item_t  s1_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                item_kind,
  output logic [47:0]         time_offset,
  output logic signed [39:0]  carrier_phase,
  output logic [5:0]          tap_index,
  output logic signed [16:0]  i_value,
  output logic signed [16:0]  q_value,
  output logic                last_tap
);

  logic signed [34:0] prod_i;
  logic signed [34:0] prod_q;
  logic signed [34:0] adj_i;
  logic signed [34:0] adj_q;
  logic [16:0]        iv;
  logic [16:0]        qv;
  logic               load;

  assign s1_stall = out_valid && out_stall;
  assign load     = !s1_stall;

  assign prod_i = $signed({1'b0, s1_item.word_a}) * $signed(s1_item.cos_val);
  assign prod_q = $signed({1'b0, s1_item.word_a}) * $signed(s1_item.sin_val);

  // Bias negative products so the shift truncates toward zero.
  assign adj_i = prod_i + (prod_i[34] ? 35'sd65535 : 35'sd0);
  assign adj_q = prod_q + (prod_q[34] ? 35'sd65535 : 35'sd0);

  always_comb begin
    if (s1_item.amp_mode) begin
      iv = adj_i[32:16];
      qv = adj_q[32:16];
    end else begin
      iv = {s1_item.word_a[15], s1_item.word_a};
      qv = {s1_item.word_b[15], s1_item.word_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_kind <= s1_item.kind;
      if (s1_item.kind == orp_pkg::KIND_TAP) begin
        time_offset   <= '0;
        carrier_phase <= '0;
        tap_index     <= s1_item.tap_index;
        i_value       <= $signed(iv);
        q_value       <= $signed(qv);
        last_tap      <= s1_item.last_tap;
      end else begin
        time_offset   <= s1_item.time_offset;
        carrier_phase <= $signed(s1_item.carrier_phase);
        tap_index     <= '0;
        i_value       <= '0;
        q_value       <= '0;
        last_tap      <= 1'b0;
      end
    end
  end

  `include "occultation_record_parser_core_assert.svh"

  `ORP_ASSERT_NOW(a_header_tap_fields, clk, rst, out_valid && item_kind == orp_pkg::KIND_HEADER, i_value == 17'sd0 && q_value == 17'sd0 && last_tap == 1'b0 && tap_index == 6'd0, "header result carries tap fields")
  `ORP_ASSERT_NOW(a_tap_header_fields, clk, rst, out_valid && item_kind == orp_pkg::KIND_TAP, time_offset == 48'd0 && carrier_phase == 40'sd0, "tap result carries header fields")

endmodule
